FILE: rtl/core/lcd_window_bus_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// lcd_window_bus_sequencer_core_macros
// Assertion macros for the LCD window bus sequencer.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_BUS_SEQUENCER_CORE_MACROS_SVH
`define LCD_WINDOW_BUS_SEQUENCER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property that holds at every sampled edge outside reset.
`define LCDWS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define LCDWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCDWS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define LCDWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types and constants shared by the LCD window bus sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    // Input item kinds
    typedef enum logic [2:0] {
        KIND_OPEN_WRITE = 3'd0,
        KIND_PIXEL      = 3'd1,
        KIND_OPEN_READ  = 3'd2,
        KIND_READ_WORD  = 3'd3,
        KIND_CLOSE_READ = 3'd4
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PANEL_WIDTH      = 2'd0,
        CFG_ACCESS_LANDSCAPE = 2'd1,
        CFG_ACCESS_PORTRAIT  = 2'd2
    } t_cfg_index;

    localparam int CFG_DATA_W = 11;

    // Panel command codes and format parameters
    localparam logic [15:0] CMD_ACCESS       = 16'h0036;
    localparam logic [15:0] CMD_COLUMN       = 16'h002A;
    localparam logic [15:0] CMD_PAGE         = 16'h002B;
    localparam logic [15:0] CMD_MEM_WRITE    = 16'h002C;
    localparam logic [15:0] CMD_MEM_READ     = 16'h002E;
    localparam logic [15:0] CMD_PIXEL_FORMAT = 16'h003A;
    localparam logic [15:0] FORMAT_READ      = 16'h0006;
    localparam logic [15:0] FORMAT_NORMAL    = 16'h0005;

    // Readback decoder phase
    typedef enum logic [1:0] {
        PH_DUMMY  = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_THIRD  = 2'd3
    } t_rd_phase;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        JOB_WIN_WRITE  = 3'd0,
        JOB_WIN_READ   = 3'd1,
        JOB_PIXEL      = 3'd2,
        JOB_READ_PIXEL = 3'd3,
        JOB_CLOSE      = 3'd4
    } t_job_op;

    // Sequencer steps of a window burst
    localparam logic [3:0] STEP_WIN_TAIL  = 4'd12;
    localparam logic [3:0] STEP_WRITE_END = 4'd12;
    localparam logic [3:0] STEP_READ_END  = 4'd14;
    localparam logic [3:0] STEP_CLOSE_END = 4'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic        portrait;
        logic [15:0] pixel_in;
        logic [15:0] read_word;
    } t_item;

    typedef struct packed {
        logic        bus_write;
        logic        is_command;
        logic [15:0] bus_word;
        logic        pixel_valid;
        logic [15:0] pixel_out;
        logic        last;
    } t_result;

    typedef struct packed {
        t_job_op     op;
        logic [7:0]  access;
        logic [15:0] col_start;
        logic [15:0] col_end;
        logic [15:0] page_start;
        logic [15:0] page_end;
        logic [15:0] data;
    } t_job;

endpackage

FILE: rtl/core/lcdws_fifo.sv
// ----------------------------------------------------------------------------
// lcdws_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lcdws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (wr_en && !rd_en) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (rd_en && !wr_en) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Classify input words, run the readback decoder, build back-end jobs.
// ----------------------------------------------------------------------------
module lcdws_front
    import lcdws_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_item       i_item,
    input  logic [10:0] i_panel_width,
    input  logic [7:0]  i_access_landscape,
    input  logic [7:0]  i_access_portrait,
    output logic        o_job_push,
    output t_job        o_job
);

    t_rd_phase   r_phase, n_phase;
    logic        r_armed, n_armed;
    logic [15:0] r_held, n_held;

    logic [16:0] v_x, v_y, v_w, v_h, v_pw;
    logic [16:0] land_xe, land_ye, port_ys, port_ye;
    logic [15:0] px_second, px_third;

    // Window coordinates, wide enough to hold any carry, then wrapped
    assign v_x  = 17'(i_item.rect_x);
    assign v_y  = 17'(i_item.rect_y);
    assign v_w  = 17'(i_item.rect_width);
    assign v_h  = 17'(i_item.rect_height);
    assign v_pw = 17'(i_panel_width);

    assign land_xe = v_x + v_w - 17'd1;
    assign land_ye = v_y + v_h - 17'd1;
    assign port_ys = v_pw - (v_x + v_w);
    assign port_ye = v_pw - v_x - 17'd1;

    // Unpack two RGB565 pixels from three 18-bit-per-pixel words
    assign px_second = {r_held[15:11], r_held[7:2], i_item.read_word[15:11]};
    assign px_third  = {r_held[7:3], i_item.read_word[15:10], i_item.read_word[7:3]};

    // Decoder next state
    always_comb begin
        n_phase = r_phase;
        n_armed = r_armed;
        n_held  = r_held;
        if (i_accept) begin
            unique case (t_kind'(i_item.kind))
                KIND_OPEN_WRITE: begin
                    n_armed = 1'b0;
                    n_phase = PH_DUMMY;
                end
                KIND_OPEN_READ: begin
                    n_armed = 1'b1;
                    n_phase = PH_DUMMY;
                end
                KIND_READ_WORD: begin
                    if (r_armed) begin
                        unique case (r_phase)
                            PH_DUMMY:  n_phase = PH_FIRST;
                            PH_FIRST: begin
                                n_held  = i_item.read_word;
                                n_phase = PH_SECOND;
                            end
                            PH_SECOND: begin
                                n_held  = i_item.read_word;
                                n_phase = PH_THIRD;
                            end
                            PH_THIRD:  n_phase = PH_FIRST;
                            default:   n_phase = PH_DUMMY;
                        endcase
                    end
                end
                KIND_CLOSE_READ: begin
                    n_armed = 1'b0;
                    n_phase = PH_DUMMY;
                end
                default: ;
            endcase
        end
    end

    // Job build
    always_comb begin
        o_job_push = 1'b0;
        o_job.op   = JOB_PIXEL;
        o_job.data = i_item.pixel_in;
        if (i_item.portrait) begin
            o_job.access     = i_access_portrait;
            o_job.col_start  = 16'(v_y[COORD_BITS-1:0]);
            o_job.col_end    = 16'(land_ye[COORD_BITS-1:0]);
            o_job.page_start = 16'(port_ys[COORD_BITS-1:0]);
            o_job.page_end   = 16'(port_ye[COORD_BITS-1:0]);
        end else begin
            o_job.access     = i_access_landscape;
            o_job.col_start  = 16'(v_x[COORD_BITS-1:0]);
            o_job.col_end    = 16'(land_xe[COORD_BITS-1:0]);
            o_job.page_start = 16'(v_y[COORD_BITS-1:0]);
            o_job.page_end   = 16'(land_ye[COORD_BITS-1:0]);
        end
        unique case (t_kind'(i_item.kind))
            KIND_OPEN_WRITE: begin
                o_job_push = i_accept;
                o_job.op   = JOB_WIN_WRITE;
            end
            KIND_PIXEL: begin
                o_job_push = i_accept;
                o_job.op   = JOB_PIXEL;
            end
            KIND_OPEN_READ: begin
                o_job_push = i_accept;
                o_job.op   = JOB_WIN_READ;
            end
            KIND_READ_WORD: begin
                o_job.op = JOB_READ_PIXEL;
                if (r_phase == PH_SECOND) begin
                    o_job_push = i_accept && r_armed;
                    o_job.data = px_second;
                end else if (r_phase == PH_THIRD) begin
                    o_job_push = i_accept && r_armed;
                    o_job.data = px_third;
                end
            end
            KIND_CLOSE_READ: begin
                o_job_push = i_accept && r_armed;
                o_job.op   = JOB_CLOSE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DUMMY;
            r_armed <= 1'b0;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_held  <= n_held;
        end
    end

endmodule

FILE: rtl/core/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Step through each job and emit its bus words or decoded pixel.
// ----------------------------------------------------------------------------
module lcdws_back
    import lcdws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_empty,
    input  t_job    i_job,
    output logic    o_job_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_result o_result
);

    logic [3:0]  r_step, n_step;
    logic [3:0]  last_step;
    logic        is_last;
    logic        win_cmd;
    logic [15:0] win_word;

    always_comb begin
        case (i_job.op)
            JOB_WIN_WRITE: last_step = STEP_WRITE_END;
            JOB_WIN_READ:  last_step = STEP_READ_END;
            JOB_CLOSE:     last_step = STEP_CLOSE_END;
            default:       last_step = '0;
        endcase
    end

    assign is_last    = (r_step == last_step);
    assign o_out_push = !i_job_empty && !i_out_full;
    assign o_job_pop  = o_out_push && is_last;

    // Window setup words, shared by both window kinds
    always_comb begin
        win_cmd  = 1'b0;
        win_word = '0;
        unique case (r_step)
            4'd0: begin
                win_cmd  = 1'b1;
                win_word = CMD_ACCESS;
            end
            4'd1:  win_word = 16'(i_job.access);
            4'd2: begin
                win_cmd  = 1'b1;
                win_word = CMD_COLUMN;
            end
            4'd3:  win_word = 16'(i_job.col_start[15:8]);
            4'd4:  win_word = 16'(i_job.col_start[7:0]);
            4'd5:  win_word = 16'(i_job.col_end[15:8]);
            4'd6:  win_word = 16'(i_job.col_end[7:0]);
            4'd7: begin
                win_cmd  = 1'b1;
                win_word = CMD_PAGE;
            end
            4'd8:  win_word = 16'(i_job.page_start[15:8]);
            4'd9:  win_word = 16'(i_job.page_start[7:0]);
            4'd10: win_word = 16'(i_job.page_end[15:8]);
            4'd11: win_word = 16'(i_job.page_end[7:0]);
            4'd12: begin
                win_cmd  = 1'b1;
                win_word = (i_job.op == JOB_WIN_WRITE) ? CMD_MEM_WRITE : CMD_PIXEL_FORMAT;
            end
            4'd13: win_word = FORMAT_READ;
            4'd14: begin
                win_cmd  = 1'b1;
                win_word = CMD_MEM_READ;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.bus_write   = 1'b1;
        o_result.is_command  = win_cmd;
        o_result.bus_word    = win_word;
        o_result.pixel_valid = 1'b0;
        o_result.pixel_out   = '0;
        o_result.last        = is_last;
        case (i_job.op)
            JOB_PIXEL: begin
                o_result.is_command = 1'b0;
                o_result.bus_word   = i_job.data;
            end
            JOB_READ_PIXEL: begin
                o_result.bus_write   = 1'b0;
                o_result.is_command  = 1'b0;
                o_result.bus_word    = '0;
                o_result.pixel_valid = 1'b1;
                o_result.pixel_out   = i_job.data;
            end
            JOB_CLOSE: begin
                o_result.is_command = (r_step == '0);
                o_result.bus_word   = (r_step == '0) ? CMD_PIXEL_FORMAT : FORMAT_NORMAL;
            end
            default: ;
        endcase
    end

    // Advance one word per free output slot; restart on job retire
    always_comb begin
        n_step = r_step;
        if (o_job_pop) begin
            n_step = '0;
        end else if (o_out_push) begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: rtl/core/lcd_window_bus_sequencer_core.sv
// ----------------------------------------------------------------------------
// lcd_window_bus_sequencer_core
// Host side of a 16-bit 8080-style LCD bus: window setup, pixel pass-through
// and readback pixel unpacking.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload      Direction
//  --------  -----------------  -----------  ---------------------------------
//  item      push / full        i_item       input words into the front
//  result    empty / pop        o_result     bus words and decoded pixels out
//  config    i_cfg_we           i_cfg_index  panel width, access parameters
//                               i_cfg_data
//
//  Each accepted word is classified in the cycle it arrives and becomes at
//  most one job in the job queue; the readback decoder updates there too.
//  The back emits one result word per cycle while a job waits and the result
//  queue has room; a pixel is one word, a write window 13, a read window 15, a
//  close 2. The step sequencer sets the rate; results pass both queues.
//  Reset (synchronous, active low) empties both queues, idles the decoder and
//  restores the register defaults. A full result queue stalls the back only;
//  the front keeps accepting until the job queue fills.
//
`include "lcd_window_bus_sequencer_core_macros.svh"

module lcd_window_bus_sequencer_core
    import lcdws_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int JOB_DEPTH  = 4,
    parameter int OUT_DEPTH  = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item side
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [10:0] r_panel_width;
    logic [7:0]  r_access_landscape;
    logic [7:0]  r_access_portrait;

    logic    accept;
    logic    job_push;
    t_job    job_in;
    logic    job_empty;
    logic    job_pop;
    t_job    job_head;
    logic    out_full;
    logic    out_push;
    t_result out_word;

    assign accept = push && !full;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width      <= 11'd320;
            r_access_landscape <= 8'hA0;
            r_access_portrait  <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PANEL_WIDTH:      r_panel_width      <= i_cfg_data;
                CFG_ACCESS_LANDSCAPE: r_access_landscape <= i_cfg_data[7:0];
                CFG_ACCESS_PORTRAIT:  r_access_portrait  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: classify, decode readback, build jobs
    lcdws_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_item             (i_item),
        .i_panel_width      (r_panel_width),
        .i_access_landscape (r_access_landscape),
        .i_access_portrait  (r_access_portrait),
        .o_job_push         (job_push),
        .o_job              (job_in)
    );

    // Job queue: full here is what the item side sees
    lcdws_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    // Back: expand each job into result words
    lcdws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_result    (out_word)
    );

    // Result queue: hold finished words until popped
    lcdws_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_word),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    // A decoded pixel is a lone result and never a bus cycle
    `LCDWS_ASSERT_ALWAYS(a_pixel_lone, i_clk, i_rst_n, !empty && o_result.pixel_valid |-> o_result.last && !o_result.bus_write && !o_result.is_command, "decoded pixel not a lone data result")
    // Command words carry a one-byte opcode
    `LCDWS_ASSERT_ALWAYS(a_cmd_byte, i_clk, i_rst_n, !empty && o_result.is_command |-> o_result.bus_write && o_result.bus_word[15:8] == 8'h00, "malformed command word")
    // The back only retires a job on a word it actually emits
    `LCDWS_ASSERT_ALWAYS(a_retire_emits, i_clk, i_rst_n, job_pop |-> out_push && out_word.last, "job retired without its last word")
    // An accepted pixel write reaches the job queue
    `LCDWS_ASSERT_NEXT(a_pixel_queued, i_clk, i_rst_n, accept && i_item.kind == 3'(KIND_PIXEL), !job_empty, "pixel write lost before job queue")

endmodule

FILE: dv/lcd_window_bus_sequencer_core_check.sv
// ----------------------------------------------------------------------------
// lcd_window_bus_sequencer_core_check
// Watches the item, result and register ports of the LCD window bus
// sequencer. It works out the bus words and read pixels that each accepted
// item owes, then compares every popped word with the oldest one owed.
// ----------------------------------------------------------------------------
module lcd_window_bus_sequencer_core_check
    import lcdws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_item                 i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  t_result               i_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   COORD_BITS   = 16;
    localparam int   REPORT_LIMIT = 10;
    localparam logic AS_CMD       = 1'b1;
    localparam logic AS_DATA      = 1'b0;

    logic [10:0] panel_width;
    logic [7:0]  access_landscape;
    logic [7:0]  access_portrait;
    t_rd_phase   phase;
    logic        armed;
    logic [15:0] held;

    t_result owed_words[$];
    t_result burst[$];
    int      mismatches = 0;

    function automatic t_result bus_cycle(input logic cmd, input logic [15:0] value);
        t_result r;
        r            = '0;
        r.bus_write  = 1'b1;
        r.is_command = cmd;
        r.bus_word   = value;
        return r;
    endfunction

    function automatic t_result read_pixel(input logic [15:0] value);
        t_result r;
        r             = '0;
        r.pixel_valid = 1'b1;
        r.pixel_out   = value;
        return r;
    endfunction

    task automatic send_range(input logic [15:0] cmd, input logic [COORD_BITS-1:0] first,
                              input logic [COORD_BITS-1:0] final_pos);
        logic [15:0] a;
        logic [15:0] b;
        a = 16'(first);
        b = 16'(final_pos);
        burst.push_back(bus_cycle(AS_CMD, cmd));
        burst.push_back(bus_cycle(AS_DATA, {8'h00, a[15:8]}));
        burst.push_back(bus_cycle(AS_DATA, {8'h00, a[7:0]}));
        burst.push_back(bus_cycle(AS_DATA, {8'h00, b[15:8]}));
        burst.push_back(bus_cycle(AS_DATA, {8'h00, b[7:0]}));
    endtask

    // Access control, then column and page ranges; portrait swaps the axes
    // and mirrors against the panel width, all wrapping at the coordinate width.
    task automatic plan_window(input t_item it);
        logic [COORD_BITS-1:0] x, y, w, h, pw, cs, ce, ps, pe;
        x  = COORD_BITS'(it.rect_x);
        y  = COORD_BITS'(it.rect_y);
        w  = COORD_BITS'(it.rect_width);
        h  = COORD_BITS'(it.rect_height);
        pw = COORD_BITS'(panel_width);
        burst.push_back(bus_cycle(AS_CMD, CMD_ACCESS));
        if (!it.portrait) begin
            burst.push_back(bus_cycle(AS_DATA, {8'h00, access_landscape}));
            cs = x;
            ce = x + w - 1'b1;
            ps = y;
            pe = y + h - 1'b1;
        end else begin
            burst.push_back(bus_cycle(AS_DATA, {8'h00, access_portrait}));
            cs = y;
            ce = y + h - 1'b1;
            ps = pw - (x + w);
            pe = pw - x - 1'b1;
        end
        send_range(CMD_COLUMN, cs, ce);
        send_range(CMD_PAGE, ps, pe);
    endtask

    task automatic sequence_item(input t_item it);
        burst.delete();
        case (it.kind)
            KIND_OPEN_WRITE: begin
                plan_window(it);
                burst.push_back(bus_cycle(AS_CMD, CMD_MEM_WRITE));
                armed = 1'b0;
                phase = PH_DUMMY;
            end
            KIND_PIXEL: begin
                burst.push_back(bus_cycle(AS_DATA, it.pixel_in));
            end
            KIND_OPEN_READ: begin
                plan_window(it);
                burst.push_back(bus_cycle(AS_CMD, CMD_PIXEL_FORMAT));
                burst.push_back(bus_cycle(AS_DATA, FORMAT_READ));
                burst.push_back(bus_cycle(AS_CMD, CMD_MEM_READ));
                armed = 1'b1;
                phase = PH_DUMMY;
            end
            KIND_READ_WORD: begin
                if (armed) begin
                    case (phase)
                        PH_DUMMY: phase = PH_FIRST;
                        PH_FIRST: begin
                            held  = it.read_word;
                            phase = PH_SECOND;
                        end
                        PH_SECOND: begin
                            burst.push_back(read_pixel({held[15:11], held[7:2],
                                                        it.read_word[15:11]}));
                            held  = it.read_word;
                            phase = PH_THIRD;
                        end
                        default: begin
                            burst.push_back(read_pixel({held[7:3], it.read_word[15:10],
                                                        it.read_word[7:3]}));
                            phase = PH_FIRST;
                        end
                    endcase
                end
            end
            KIND_CLOSE_READ: begin
                if (armed) begin
                    burst.push_back(bus_cycle(AS_CMD, CMD_PIXEL_FORMAT));
                    burst.push_back(bus_cycle(AS_DATA, FORMAT_NORMAL));
                    armed = 1'b0;
                    phase = PH_DUMMY;
                end
            end
            default: ;
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[k]) owed_words.push_back(burst[k]);
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        logic    bad;
        if (owed_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected word bw=%0d cmd=%0d word=%h pv=%0d px=%h last=%0d",
                         $realtime, got.bus_write, got.is_command, got.bus_word,
                         got.pixel_valid, got.pixel_out, got.last);
        end else begin
            want = owed_words.pop_front();
            bad  = (got.bus_write != want.bus_write) || (got.is_command != want.is_command)
                || (got.bus_word != want.bus_word) || (got.pixel_valid != want.pixel_valid)
                || (got.pixel_out != want.pixel_out) || (got.last != want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: mismatch expected bw=%0d cmd=%0d word=%h pv=%0d px=%h last=%0d",
                             $realtime, want.bus_write, want.is_command, want.bus_word,
                             want.pixel_valid, want.pixel_out, want.last);
                    $display("%0t:          actual   bw=%0d cmd=%0d word=%h pv=%0d px=%h last=%0d",
                             $realtime, got.bus_write, got.is_command, got.bus_word,
                             got.pixel_valid, got.pixel_out, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            panel_width      = 11'd320;
            access_landscape = 8'hA0;
            access_portrait  = 8'h00;
            phase            = PH_DUMMY;
            armed            = 1'b0;
            held             = '0;
            owed_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PANEL_WIDTH:      panel_width      = i_cfg_data[10:0];
                    CFG_ACCESS_LANDSCAPE: access_landscape = i_cfg_data[7:0];
                    CFG_ACCESS_PORTRAIT:  access_portrait  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) sequence_item(i_item);
            if (i_pop && !i_empty) check_word(i_result);
        end
        o_mismatches <= mismatches;
        o_owed       <= owed_words.size();
    end

endmodule

FILE: dv/lcd_window_bus_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// lcd_window_bus_sequencer_core_test
// Drives window setup, pixel writes and readback sequences into the LCD window
// bus sequencer with random gaps on the item side and random stalls on the
// result side, over several register settings; a side checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module lcd_window_bus_sequencer_core_test;
    import lcdws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind codes the block must ignore, and the register index past the list
    localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
    localparam logic [2:0] KIND_RESERVED_HI = 3'd7;
    localparam logic [1:0] CFG_SPARE        = 2'd3;

    localparam int MAX_GAP       = 14;
    localparam int PHASE_WORDS   = 42;     // five phases; with the directed words about 260
    localparam int SETTLE_CYCLES = 12;     // margin after the last owed word for the back's quiet work
    localparam int TIMEOUT_NS    = 5_000_000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  pop         = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    t_item                 i_item      = '0;
    logic                  full;
    logic                  empty;
    t_result               o_result;

    int   mismatches;
    int   owed;
    int   counted      = 0;   // words this phase that the block acts on
    logic window_armed = 1'b0;
    logic in_steady    = 1'b0;
    logic out_steady   = 1'b0;

    always #5 i_clk = ~i_clk;

    lcd_window_bus_sequencer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lcd_window_bus_sequencer_core_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    // Fill every field with noise; only the fields the kind uses matter.
    function automatic t_item make_item(input logic [2:0] kind);
        t_item it;
        it.kind        = kind;
        it.rect_x      = 10'($urandom);
        it.rect_y      = 10'($urandom);
        it.rect_width  = 11'($urandom);
        it.rect_height = 11'($urandom);
        it.portrait    = 1'($urandom);
        it.pixel_in    = 16'($urandom);
        it.read_word   = 16'($urandom);
        return it;
    endfunction

    // Present one word at the falling edge and hold it until the rising edge
    // that takes it. Leave push high on return: the caller's next word, gap or
    // settle decides it at this same falling edge.
    task automatic send_word(input t_item it);
        int   gap;
        logic ignored;
        if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        // Count only words the block acts on; track the read window for that
        ignored = (it.kind >= KIND_RESERVED_LO)
               || ((it.kind == KIND_READ_WORD || it.kind == KIND_CLOSE_READ) && !window_armed);
        if (!ignored) counted++;
        if (it.kind == KIND_OPEN_READ) window_armed = 1'b1;
        else if (it.kind == KIND_OPEN_WRITE || it.kind == KIND_CLOSE_READ) window_armed = 1'b0;
    endtask

    task automatic send_window(input logic [2:0] kind, input logic [9:0] x, input logic [9:0] y,
                               input logic [10:0] w, input logic [10:0] h, input logic portrait);
        t_item it;
        it             = make_item(kind);
        it.rect_x      = x;
        it.rect_y      = y;
        it.rect_width  = w;
        it.rect_height = h;
        it.portrait    = portrait;
        send_word(it);
    endtask

    // Set the field the kind reads; leave the other one as noise.
    task automatic send_value(input logic [2:0] kind, input logic [15:0] value);
        t_item it;
        it = make_item(kind);
        if (kind == KIND_PIXEL) it.pixel_in = value;
        else it.read_word = value;
        send_word(it);
    endtask

    // Mostly legal panel sizes; now and then any 11-bit size, zero included.
    task automatic send_random_window(input logic [2:0] kind);
        logic [10:0] w;
        logic [10:0] h;
        w = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
        h = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
        send_window(kind, 10'($urandom), 10'($urandom), w, h, 1'($urandom));
    endtask

    // One random sequence: mostly well-formed write or read windows with random
    // content, some stray words, some reads cut short by a new window.
    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_random_window(KIND_OPEN_WRITE);
            n = $urandom_range(1, 12);
            repeat (n) send_value(KIND_PIXEL, 16'($urandom));
        end else if (pick < 75) begin
            send_random_window(KIND_OPEN_READ);
            // Dummy word first, then whole groups of three, sometimes a ragged tail
            n = 1 + 3 * $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2);
            repeat (n) send_value(KIND_READ_WORD, 16'($urandom));
            if ($urandom_range(0, 9) != 0) send_value(KIND_CLOSE_READ, 16'($urandom));
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0: send_value(KIND_READ_WORD, 16'($urandom));
                1: send_value(KIND_CLOSE_READ, 16'($urandom));
                2: send_value(KIND_PIXEL, 16'($urandom));
                default: send_value(3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI)),
                                    16'($urandom));
            endcase
        end else begin
            send_random_window(KIND_OPEN_READ);
            n = $urandom_range(0, 4);
            repeat (n) send_value(KIND_READ_WORD, 16'($urandom));
            send_random_window($urandom_range(0, 1) ? KIND_OPEN_WRITE : KIND_OPEN_READ);
        end
    endtask

    task automatic run_random(input int quota);
        counted = 0;
        while (counted < quota) random_sequence();
    endtask

    // Drop push, wait for every owed word, then let the back drain its
    // quiet work (dummy and first words of a group leave no word behind).
    task automatic settle();
        push <= 1'b0;
        while (owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    // Write all three registers back to back, plus the spare index that the
    // block must drop. Junk goes in the upper data bits of the 8-bit registers.
    task automatic configure(input logic [10:0] width, input logic [7:0] landscape,
                             input logic [7:0] portrait);
        write_reg(CFG_PANEL_WIDTH, width);
        write_reg(CFG_ACCESS_LANDSCAPE, {3'($urandom), landscape});
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_ACCESS_PORTRAIT, {3'($urandom), portrait});
        i_cfg_we <= 1'b0;
    endtask

    // Result side: pop with a fresh random stall before every word, with
    // stretches of back-to-back pops now and then.
    initial begin : result_side
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
            stall = out_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    initial begin : item_side
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset register values.
        // Smallest landscape window, then both pixel extremes
        send_window(KIND_OPEN_WRITE, 10'd0, 10'd0, 11'd1, 11'd1, 1'b0);
        send_value(KIND_PIXEL, 16'h0000);
        send_value(KIND_PIXEL, 16'hFFFF);
        // Largest field values in portrait, then zero size: both wrap
        send_window(KIND_OPEN_WRITE, 10'd1023, 10'd1023, 11'd2047, 11'd2047, 1'b1);
        send_window(KIND_OPEN_WRITE, 10'd1023, 10'd1023, 11'd0, 11'd0, 1'b0);
        // Read word and close with no read window open: both dropped
        send_value(KIND_READ_WORD, 16'hFFFF);
        send_value(KIND_CLOSE_READ, 16'h0000);
        // Kinds past the list: dropped
        for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++)
            send_value(3'(k), 16'hFFFF);
        // Full-panel portrait read: dummy, then one group of three
        send_window(KIND_OPEN_READ, 10'd0, 10'd0, 11'd1024, 11'd1024, 1'b1);
        send_value(KIND_READ_WORD, 16'hFFFF);
        send_value(KIND_READ_WORD, 16'hFFFF);
        send_value(KIND_READ_WORD, 16'h0000);
        send_value(KIND_READ_WORD, 16'hFFFF);
        // Reopen a read window halfway through a group: decoder restarts
        send_value(KIND_READ_WORD, 16'h1234);
        send_window(KIND_OPEN_READ, 10'd512, 10'd7, 11'd1, 11'd1024, 1'b0);
        send_value(KIND_READ_WORD, 16'h0000);
        send_value(KIND_READ_WORD, 16'h8421);
        // Write window while reading: decoder off, format left alone
        send_window(KIND_OPEN_WRITE, 10'd3, 10'd5, 11'd16, 11'd9, 1'b1);
        send_value(KIND_READ_WORD, 16'h5A5A);
        send_value(KIND_CLOSE_READ, 16'h0000);
        // Open and close a read window with nothing read
        send_window(KIND_OPEN_READ, 10'd100, 10'd200, 11'd300, 11'd400, 1'b0);
        send_value(KIND_CLOSE_READ, 16'h0000);
        settle();

        // Random phases over register settings, extremes first
        configure(11'd1, 8'h00, 8'hFF);
        run_random(PHASE_WORDS);
        settle();
        configure(11'd2047, 8'hFF, 8'h00);
        run_random(PHASE_WORDS);
        settle();
        configure(11'd0, 8'h5A, 8'hA5);
        run_random(PHASE_WORDS);
        settle();
        configure(11'd1024, 8'($urandom), 8'($urandom));
        run_random(PHASE_WORDS);
        settle();
        configure(11'($urandom_range(1, 1024)), 8'($urandom), 8'($urandom));
        run_random(PHASE_WORDS);
        settle();

        if (mismatches == 0 && owed == 0) begin
            $display("lcd_window_bus_sequencer_core verification clean");
        end else begin
            $display("lcd_window_bus_sequencer_core verification failed");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("lcd_window_bus_sequencer_core verification failed");
        $finish;
    end

endmodule
